// ===== rtl/palette_gradient_entry_macros.svh =====
// Assertion helpers shared by the palette gradient RTL.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef PALETTE_GRADIENT_ENTRY_MACROS_SVH
`define PALETTE_GRADIENT_ENTRY_MACROS_SVH

// Same-cycle implication.
`define PGE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PGE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pge_pkg.sv =====
`timescale 1ns / 1ps
package pge_pkg;

  // Field widths
  localparam int SLOT_W     = 4;
  localparam int CH_W       = 8;
  localparam int CHANNELS   = 4;
  localparam int WORD_W     = CH_W * CHANNELS;
  localparam int INDEX_W    = 14;
  localparam int COLOR_W    = 4;
  localparam int SHADE_W    = 9;
  localparam int HALF_W     = COLOR_W + SHADE_W;
  localparam int NUM_W      = CH_W + SHADE_W;

  // Stream payload layout
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int RED_LSB    = SLOT_W;
  localparam int INDEX_LSB  = SLOT_W + WORD_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHADE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR      = 2'd2;
  localparam logic [COLOR_W-1:0]   COLOR_COUNT_RST = 4'd12;
  localparam logic [SHADE_W-1:0]   SHADE_COUNT_RST = 9'd30;

  // Input kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] color_count;
    logic [SHADE_W-1:0] shade_count;
    logic               mirror;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_READ,
    OP_RANGE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] color;
    logic [HALF_W-1:0] j;
    logic [SHADE_W-1:0] shades;
  } cmd_t;

  typedef struct packed {
    logic                               start;
    logic [CHANNELS-1:0][NUM_W-1:0]     dividend;
    logic [SHADE_W-1:0]                 divisor;
  } div_req_t;

  typedef struct packed {
    logic                               busy;
    logic [CHANNELS-1:0][NUM_W-1:0]     quotient;
    logic [CHANNELS-1:0][SHADE_W-1:0]   remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYDIV,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_CHDIV,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/pge_ram.sv =====
`timescale 1ns / 1ps
module pge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pge_front.sv =====
`timescale 1ns / 1ps
module pge_front #(
  parameter int KEY_SLOTS  = 12,
  parameter int MAX_SHADES = 360
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pge_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pge_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic                              in_kind_i,
  output pge_pkg::cmd_t                     cmd_o,
  output logic                              cmd_valid_o,
  input  logic                              cmd_pop_i
);
  import pge_pkg::*;

  logic [SLOT_W-1:0]  slot;
  logic [INDEX_W-1:0] idx;
  logic [COLOR_W-1:0] c_eff;
  logic [SHADE_W-1:0] s_eff;
  logic [HALF_W-1:0]  half;
  logic [INDEX_W-1:0] total;
  logic [INDEX_W-1:0] j_wide;
  logic               keep;
  logic               push;
  cmd_t               cmd_new;

  cmd_t               q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;

  assign slot = in_data_i[SLOT_W-1:0];
  assign idx  = in_data_i[INDEX_LSB +: INDEX_W];

  // Counts above the supported range saturate
  assign c_eff = (cfg_i.color_count > KEY_SLOTS) ? COLOR_W'(KEY_SLOTS) : cfg_i.color_count;
  assign s_eff = (cfg_i.shade_count > MAX_SHADES) ? SHADE_W'(MAX_SHADES) : cfg_i.shade_count;
  assign half  = HALF_W'(c_eff) * HALF_W'(s_eff);
  assign total = {half, 1'b0};

  // Fold the index into the first half
  always_comb begin
    if (idx < INDEX_W'(half)) begin
      j_wide = idx;
    end else if (cfg_i.mirror) begin
      j_wide = total - INDEX_W'(1) - idx;
    end else begin
      j_wide = idx - INDEX_W'(half);
    end
  end

  // Classify the item
  always_comb begin
    cmd_new.slot   = slot;
    cmd_new.color  = in_data_i[RED_LSB +: WORD_W];
    cmd_new.j      = j_wide[HALF_W-1:0];
    cmd_new.shades = s_eff;
    keep           = 1'b1;
    if (in_kind_i == KIND_LOAD) begin
      cmd_new.op = OP_LOAD;
      keep       = (slot < KEY_SLOTS);
    end else if (idx >= total) begin
      cmd_new.op = OP_RANGE;
    end else begin
      cmd_new.op = OP_READ;
    end
  end

  assign in_ready_o  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !cmd_pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (!push && cmd_pop_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/pge_div.sv =====
`timescale 1ns / 1ps
module pge_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pge_pkg::div_req_t req_i,
  output pge_pkg::div_rsp_t rsp_o
);
  import pge_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]                 cnt_q;
  logic [SHADE_W-1:0]               divisor_q;
  logic [CHANNELS-1:0][NUM_W-1:0]   quo_q, quo_d;
  logic [CHANNELS-1:0][SHADE_W-1:0] rem_q, rem_d;
  logic [SHADE_W:0]                 shifted [CHANNELS];
  logic [SHADE_W:0]                 diff    [CHANNELS];
  logic                             ge      [CHANNELS];

  // One restoring step per lane, all lanes share the divisor
  always_comb begin
    for (int l = 0; l < CHANNELS; l++) begin
      shifted[l] = {rem_q[l], quo_q[l][NUM_W-1]};
      diff[l]    = shifted[l] - {1'b0, divisor_q};
      ge[l]      = (shifted[l] >= {1'b0, divisor_q});
      rem_d[l]   = ge[l] ? diff[l][SHADE_W-1:0] : shifted[l][SHADE_W-1:0];
      quo_d[l]   = {quo_q[l][NUM_W-2:0], ge[l]};
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Partial remainders and quotients
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy      = (cnt_q != '0);
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/pge_back.sv =====
`timescale 1ns / 1ps
module pge_back #(
  parameter int KEY_SLOTS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pge_pkg::cmd_t                    cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  output logic                             ram_we_o,
  output logic [$clog2(KEY_SLOTS)-1:0]     ram_waddr_o,
  output logic [pge_pkg::WORD_W-1:0]       ram_wdata_o,
  output logic [$clog2(KEY_SLOTS)-1:0]     ram_raddr_o,
  input  logic [pge_pkg::WORD_W-1:0]       ram_rdata_i,
  output pge_pkg::div_req_t                div_req_o,
  input  pge_pkg::div_rsp_t                div_rsp_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pge_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                             out_err_o
);
  import pge_pkg::*;

  localparam int KW = $clog2(KEY_SLOTS);

  state_e                         state_q, state_d;
  logic [KW-1:0]                  key_q, key_d, knext;
  logic [SHADE_W-1:0]             step_q, s_q, w0;
  logic                           err_q;
  logic [WORD_W-1:0]              k0_q;
  logic [CHANNELS-1:0][NUM_W-1:0] numer;
  logic                           out_load;
  logic                           out_valid_q, out_err_q;
  logic [OUT_DATA_W-1:0]          out_data_q, out_pick;

  // Key and neighbor slot
  assign key_d = (div_rsp_i.quotient[0] >= NUM_W'(KEY_SLOTS)) ? KW'(KEY_SLOTS - 1)
                                                              : KW'(div_rsp_i.quotient[0]);
  assign knext = (key_q == KW'(KEY_SLOTS - 1)) ? '0 : key_q + KW'(1);

  // Weighted sum per channel: k0*(S-step) + k1*step
  assign w0 = s_q - step_q;
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      numer[ch] = NUM_W'(k0_q[ch*CH_W +: CH_W]) * NUM_W'(w0)
                + NUM_W'(ram_rdata_i[ch*CH_W +: CH_W]) * NUM_W'(step_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_READ:  state_d = ST_KEYDIV;
            OP_RANGE: state_d = ST_OUT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_KEYDIV: begin
        if (!div_rsp_i.busy) state_d = ST_RD0;
      end
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_CHDIV;
      ST_CHDIV: begin
        if (!div_rsp_i.busy) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    cmd_pop_o          = 1'b0;
    ram_we_o           = 1'b0;
    ram_waddr_o        = KW'(cmd_i.slot);
    ram_wdata_o        = cmd_i.color;
    ram_raddr_o        = key_q;
    div_req_o.start    = 1'b0;
    div_req_o.divisor  = s_q;
    div_req_o.dividend = numer;
    out_load           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_LOAD) begin
            ram_we_o = 1'b1;
          end
          if (cmd_i.op == OP_READ) begin
            div_req_o.start       = 1'b1;
            div_req_o.divisor     = cmd_i.shades;
            div_req_o.dividend    = '0;
            div_req_o.dividend[0] = NUM_W'(cmd_i.j);
          end
        end
      end
      ST_RD1:  ram_raddr_o     = knext;
      ST_MUL:  div_req_o.start = 1'b1;
      ST_OUT:  out_load        = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Low byte of each lane quotient, zeros on an index error
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      out_pick[ch*CH_W +: CH_W] = err_q ? '0 : div_rsp_i.quotient[ch][CH_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      s_q   <= cmd_i.shades;
      err_q <= (cmd_i.op == OP_RANGE);
    end
    if (state_q == ST_KEYDIV && !div_rsp_i.busy) begin
      key_q  <= key_d;
      step_q <= div_rsp_i.remainder[0];
    end
    if (state_q == ST_RD1) begin
      k0_q <= ram_rdata_i;
    end
    if (out_load) begin
      out_data_q <= out_pick;
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_err_o   = out_err_q;

endmodule

// ===== rtl/palette_gradient_entry.sv =====
// A read gives its result after two 17-step restoring divisions by the shade count and
// two key table reads; an index error gives its result and a key load is written to the
// key table without the divider. The back end takes one command at a time, so a read
// holds later commands until the shared four-lane divider is through with it.
// Reset: 12 colors, 30 shades, no mirror; queue and output clear; key table not cleared.
`timescale 1ns / 1ps
`include "palette_gradient_entry_macros.svh"
module palette_gradient_entry #(
  parameter int KEY_SLOTS  = 12,
  parameter int MAX_SHADES = 360
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pge_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pge_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key_slot[3:0], key_red[11:4], key_green[19:12], key_blue[27:20],
  // key_alpha[35:28], entry_index[49:36], zero fill [55:50]
  input  logic [pge_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [pge_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // index_error[0]
  output logic [0:0]                        m_axis_tuser
);
  import pge_pkg::*;

  localparam int KW = $clog2(KEY_SLOTS);

  cfg_t          cfg_q;
  cmd_t          cmd;
  logic          cmd_valid, cmd_pop;
  logic          ram_we;
  logic [KW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  logic          out_err;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_count <= COLOR_COUNT_RST;
      cfg_q.shade_count <= SHADE_COUNT_RST;
      cfg_q.mirror      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLOR_COUNT: cfg_q.color_count <= cfg_data_i[COLOR_W-1:0];
        CFG_SHADE_COUNT: cfg_q.shade_count <= cfg_data_i[SHADE_W-1:0];
        CFG_MIRROR:      cfg_q.mirror      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify and queue
  pge_front #(
    .KEY_SLOTS  (KEY_SLOTS),
    .MAX_SHADES (MAX_SHADES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser[0]),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute commands
  pge_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (out_err)
  );

  assign m_axis_tuser[0] = out_err;

  // Shared divider
  pge_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Key color table
  pge_ram #(
    .WIDTH (WORD_W),
    .DEPTH (KEY_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks
  `PGE_ASSERT_IMP(a_pop_nonempty, cmd_pop, cmd_valid, "command popped from empty queue")
  `PGE_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `PGE_ASSERT_NXT(a_div_runs, div_req.start, div_rsp.busy, "divider did not start")
  `PGE_ASSERT_IMP(a_result_after_div, $rose(m_axis_tvalid), !div_rsp.busy, "result before divide end")

endmodule
